>>> rtl/core/sample_log_majority_check_top_defines.svh
// Assertion macros shared by the checkers of this block.
// Each one samples on the rising edge of clk and is switched off while arst_n is low.
`ifndef SAMPLE_LOG_MAJORITY_CHECK_TOP_DEFINES_SVH
`define SAMPLE_LOG_MAJORITY_CHECK_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLMC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SLMC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/slmc_pkg.sv
package slmc_pkg;

	localparam int DATA_W  = 32;
	localparam int COUNT_W = 6;
	localparam int CHECK_W = 8;

	typedef enum logic {
		OP_APPEND = 1'b0,
		OP_CLEAR  = 1'b1
	} op_t;

	// Controls for the shared bit-vote accumulator.
	typedef struct packed {
		logic clr;
		logic acc;
	} vote_ctrl_t;

endpackage

>>> rtl/core/slmc_in_if.sv
interface slmc_in_if;
	logic                         valid;
	logic                         ready;
	logic                         op;
	logic [slmc_pkg::DATA_W-1:0]  sample_word;

	modport source (output valid, output op, output sample_word, input ready);
	modport sink   (input valid, input op, input sample_word, output ready);
endinterface

>>> rtl/core/slmc_out_if.sv
interface slmc_out_if;
	logic                         valid;
	logic                         ready;
	logic [slmc_pkg::COUNT_W-1:0] entry_count;
	logic [slmc_pkg::CHECK_W-1:0] check_word;

	modport source (output valid, output entry_count, output check_word, input ready);
	modport sink   (input valid, input entry_count, input check_word, output ready);
endinterface

>>> rtl/core/slmc_ram.sv
module slmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/slmc_vote.sv
module slmc_vote #(
	parameter int LOG_DEPTH  = 32,
	parameter int CHECK_BITS = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  slmc_pkg::vote_ctrl_t             ctrl,
	input  logic [CHECK_BITS-1:0]            bits,
	input  logic [$clog2(LOG_DEPTH+1)-1:0]   fill,
	output logic [CHECK_BITS-1:0]            check
);

	import slmc_pkg::*;

	localparam int CNT_W = $clog2(LOG_DEPTH + 1);
	// One counter per bit lane; with the count bit added it reaches LOG_DEPTH + 1.
	localparam int VW    = $clog2(LOG_DEPTH + 2);

	logic [VW-1:0]         acc_q [CHECK_BITS];
	logic [CHECK_BITS-1:0] cnt_bit;

	for (genvar j = 0; j < CHECK_BITS; j++) begin : g_lane
		logic [VW-1:0] ones;

		if (j < CNT_W) begin : g_cnt
			assign cnt_bit[j] = fill[j];
		end else begin : g_zero
			assign cnt_bit[j] = 1'b0;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				acc_q[j] <= '0;
			end else if (ctrl.clr) begin
				acc_q[j] <= '0;
			end else if (ctrl.acc) begin
				acc_q[j] <= acc_q[j] + VW'(bits[j]);
			end
		end

		// Ones win only when twice their number exceeds the number of voters.
		assign ones     = acc_q[j] + VW'(cnt_bit[j]);
		assign check[j] = {ones, 1'b0} > (VW + 1)'(LOG_DEPTH + 1);
	end

endmodule

>>> rtl/core/sample_log_majority_check_top.sv
// Channel  Role    Payload                         Meaning
// sample   sink    op, sample_word                 append a word or clear the log
// result   source  entry_count, check_word         count and bit-vote after each request
//
// An append sweeps the log memory through its single read port, one entry a cycle, into
// the shared per-bit vote counters, then passes through the last and final states to the
// result register; a clear goes straight from acceptance to the final state.
// sample.ready is high only while the sequencer is idle. A finished result waits in its
// register while result.ready is low, and a following request is still accepted meanwhile.
// Reset empties the log through the fill count alone; the memory itself is not swept.
module sample_log_majority_check_top #(
	parameter int LOG_DEPTH  = 32,
	parameter int CHECK_BITS = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	slmc_in_if.sink   sample,
	slmc_out_if.source result
);

	import slmc_pkg::*;

	localparam int AW    = $clog2(LOG_DEPTH);
	localparam int CNT_W = $clog2(LOG_DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_LAST,
		S_FIN
	} state_t;

	state_t                state_q;
	logic [CNT_W-1:0]      count_q;
	logic [AW-1:0]         head_q;
	logic [AW-1:0]         idx_q;
	logic                  rd_pend_q;
	logic                  out_valid_q;
	logic [COUNT_W-1:0]    entry_count_q;
	logic [CHECK_W-1:0]    check_word_q;

	logic                  accept;
	logic                  full;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [AW-1:0]         head_next;
	logic                  idx_last;
	logic [CHECK_BITS-1:0] rd_data;
	logic [CHECK_BITS-1:0] check_bits;
	vote_ctrl_t            vote_ctrl;

	assign sample.ready = (state_q == S_IDLE);
	assign accept       = sample.valid && sample.ready;
	assign full         = (count_q == CNT_W'(LOG_DEPTH));

	// While the log is not full the oldest entry sits in slot 0, so the valid entries are
	// always slots 0 to count - 1. Once full, the head marks the oldest slot to overwrite.
	assign wr_en     = accept && (sample.op == OP_APPEND);
	assign wr_addr   = full ? head_q : count_q[AW-1:0];
	assign head_next = (head_q == AW'(LOG_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign idx_last  = (CNT_W'(idx_q) + CNT_W'(1)) == count_q;

	assign vote_ctrl.clr = accept;
	assign vote_ctrl.acc = rd_pend_q;

	slmc_ram #(
		.WIDTH (CHECK_BITS),
		.DEPTH (LOG_DEPTH)
	) u_log (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (sample.sample_word[CHECK_BITS-1:0]),
		.raddr (idx_q),
		.rdata (rd_data)
	);

	slmc_vote #(
		.LOG_DEPTH  (LOG_DEPTH),
		.CHECK_BITS (CHECK_BITS)
	) u_vote (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (vote_ctrl),
		.bits   (rd_data),
		.fill   (count_q),
		.check  (check_bits)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			count_q       <= '0;
			head_q        <= '0;
			idx_q         <= '0;
			rd_pend_q     <= 1'b0;
			out_valid_q   <= 1'b0;
			entry_count_q <= '0;
			check_word_q  <= '0;
		end else begin
			// In the final state a taken result is replaced by the new one below.
			if (result.ready && (state_q != S_FIN)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q <= '0;
						if (sample.op == OP_CLEAR) begin
							count_q <= '0;
							head_q  <= '0;
							state_q <= S_FIN;
						end else begin
							if (full) begin
								head_q <= head_next;
							end else begin
								count_q <= count_q + 1'b1;
							end
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					rd_pend_q <= 1'b1;
					idx_q     <= idx_q + 1'b1;
					if (idx_last) begin
						state_q <= S_LAST;
					end
				end
				S_LAST: begin
					// The last read word is counted in this cycle.
					rd_pend_q <= 1'b0;
					state_q   <= S_FIN;
				end
				S_FIN: begin
					if (!out_valid_q || result.ready) begin
						out_valid_q   <= 1'b1;
						entry_count_q <= COUNT_W'(count_q);
						check_word_q  <= CHECK_W'(check_bits);
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result.valid       = out_valid_q;
	assign result.entry_count = entry_count_q;
	assign result.check_word  = check_word_q;

endmodule

>>> rtl/core/slmc_chk.sv
`include "sample_log_majority_check_top_defines.svh"

module slmc_chk #(
	parameter int LOG_DEPTH  = 32,
	parameter int CHECK_BITS = 8
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [slmc_pkg::COUNT_W-1:0] entry_count,
	input logic [slmc_pkg::CHECK_W-1:0] check_word
);

	import slmc_pkg::*;

	// A waiting result must not vanish before it is taken.
	`SLMC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

	// The block works on one request at a time.
	`SLMC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "request taken while busy")

	// The reported count never exceeds the depth of the log.
	`SLMC_ASSERT_SAME(a_count_bound, out_valid, {1'b0, entry_count} <= (COUNT_W + 1)'(LOG_DEPTH), "entry count beyond log depth")

	// An empty log has no ones to vote with.
	`SLMC_ASSERT_SAME(a_empty_check, out_valid && (entry_count == '0) && (LOG_DEPTH < 64), check_word == '0, "non-zero check word for an empty log")

endmodule

bind sample_log_majority_check_top slmc_chk #(
	.LOG_DEPTH  (LOG_DEPTH),
	.CHECK_BITS (CHECK_BITS)
) u_slmc_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (sample.valid),
	.in_ready    (sample.ready),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.entry_count (result.entry_count),
	.check_word  (result.check_word)
);

>>> sim/tb.sv
`timescale 1ns / 100ps

module tb;
	import slmc_pkg::*;

	localparam int LOG_DEPTH   = 32;
	localparam int CHECK_BITS  = 8;
	localparam int CALM_ITEMS  = 100;
	localparam int STALL_LIMIT = 1000;
	localparam int DRAIN_WAIT  = 40;

	typedef struct {
		op_t               op;
		logic [DATA_W-1:0] word;
	} sample_req_t;

	typedef struct {
		logic [COUNT_W-1:0] count;
		logic [CHECK_W-1:0] check;
	} log_status_t;

	logic clk = 1'b0;
	logic arst_n;

	slmc_in_if  sample_ch ();
	slmc_out_if result_ch ();

	sample_log_majority_check_top #(
		.LOG_DEPTH (LOG_DEPTH),
		.CHECK_BITS(CHECK_BITS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.sample(sample_ch),
		.result(result_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Shadow copy of the log, updated as each request is accepted.
	logic [DATA_W-1:0] log_words [LOG_DEPTH];
	int unsigned       log_fill;

	sample_req_t queued_samples[$];
	log_status_t due_results[$];
	int          mismatch_cnt;
	int          send_gap;
	int          hold_gap;
	int          quiet_cycles;

	function automatic logic [CHECK_W-1:0] bitwise_vote();
		logic [CHECK_W-1:0] votes;
		int unsigned        ones;
		votes = '0;
		for (int j = 0; j < CHECK_BITS && j < 32; j++) begin
			ones = (log_fill >> j) & 1;
			for (int k = 0; k < LOG_DEPTH; k++)
				ones += log_words[k][j];
			if (ones > LOG_DEPTH + 1 - ones && j < CHECK_W)
				votes[j] = 1'b1;
		end
		return votes;
	endfunction

	function automatic log_status_t apply_sample_request(sample_req_t req);
		log_status_t status;
		if (req.op == OP_CLEAR) begin
			foreach (log_words[k])
				log_words[k] = '0;
			log_fill = 0;
		end else if (log_fill >= LOG_DEPTH) begin
			for (int k = 0; k < LOG_DEPTH - 1; k++)
				log_words[k] = log_words[k + 1];
			log_words[LOG_DEPTH - 1] = req.word;
			log_fill = LOG_DEPTH;
		end else begin
			log_words[log_fill] = req.word;
			log_fill++;
		end
		status.count = log_fill[COUNT_W-1:0];
		status.check = bitwise_vote();
		return status;
	endfunction

	task automatic add_request(op_t op, logic [DATA_W-1:0] word);
		sample_req_t req;
		req.op   = op;
		req.word = word;
		queued_samples.push_back(req);
	endtask

	// Sender: drops valid between requests at random, but never near the end.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_ch.valid       <= 1'b0;
			sample_ch.op          <= OP_APPEND;
			sample_ch.sample_word <= '0;
			send_gap = 0;
		end else begin
			if (sample_ch.valid && sample_ch.ready)
				due_results.push_back(apply_sample_request(queued_samples.pop_front()));
			if (sample_ch.valid && !sample_ch.ready) begin
				// The request stays on the bus until it is taken.
			end else if (send_gap > 0) begin
				send_gap--;
				sample_ch.valid <= 1'b0;
			end else if (queued_samples.size() > CALM_ITEMS && $urandom_range(0, 5) == 0) begin
				send_gap = $urandom_range(0, 2);
				sample_ch.valid <= 1'b0;
			end else if (queued_samples.size() != 0) begin
				sample_ch.valid       <= 1'b1;
				sample_ch.op          <= queued_samples[0].op;
				sample_ch.sample_word <= queued_samples[0].word;
			end else begin
				sample_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver: compares each result with the oldest prediction and stalls at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			hold_gap = 0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (due_results.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("%0t: unexpected result count=%0d check=%02h", $realtime,
							result_ch.entry_count, result_ch.check_word);
				end else begin
					log_status_t want;
					want = due_results.pop_front();
					if (result_ch.entry_count !== want.count ||
							result_ch.check_word !== want.check) begin
						mismatch_cnt++;
						if (mismatch_cnt <= 10)
							$display("%0t: expected count=%0d check=%02h, got count=%0d check=%02h",
								$realtime, want.count, want.check,
								result_ch.entry_count, result_ch.check_word);
					end
				end
			end
			if (hold_gap > 0) begin
				hold_gap--;
				result_ch.ready <= 1'b0;
			end else if (queued_samples.size() > CALM_ITEMS && $urandom_range(0, 4) == 0) begin
				hold_gap = $urandom_range(0, 2);
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		int                density;
		logic [DATA_W-1:0] word;
		sample_ch.valid       = 1'b0;
		sample_ch.op          = OP_APPEND;
		sample_ch.sample_word = '0;
		result_ch.ready       = 1'b0;
		arst_n       = 1'b0;
		mismatch_cnt = 0;
		quiet_cycles = 0;
		log_fill     = 0;
		foreach (log_words[k])
			log_words[k] = '0;

		// Directed: clear on an empty log, extreme words, clear with a busy word,
		// then a run of low-byte ones that tips the vote just past half.
		add_request(OP_CLEAR, 32'h0000_0000);
		add_request(OP_APPEND, 32'h0000_0000);
		add_request(OP_APPEND, 32'hFFFF_FFFF);
		add_request(OP_APPEND, 32'h8000_0000);
		add_request(OP_APPEND, 32'h0000_0001);
		add_request(OP_APPEND, 32'hAAAA_AAAA);
		add_request(OP_APPEND, 32'h5555_5555);
		add_request(OP_CLEAR, 32'hFFFF_FFFF);
		for (int n = 0; n < 17; n++)
			add_request(OP_APPEND, 32'h0000_00FF);

		// Random: rare clears so the log fills and then shifts; the bit density
		// drifts between phases so the vote bits swing both ways.
		density = 2;
		for (int n = 0; n < 700; n++) begin
			if ($urandom_range(0, 39) == 0)
				density = $urandom_range(0, 2);
			if ($urandom_range(0, 99) < 2) begin
				add_request(OP_CLEAR, $urandom);
			end else begin
				case (density)
					0: word = $urandom & $urandom;
					1: word = $urandom | $urandom;
					default: word = $urandom;
				endcase
				if ($urandom_range(0, 24) == 0)
					word = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
				add_request(OP_APPEND, word);
			end
		end

		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		wait (queued_samples.size() == 0 && due_results.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
